// ----- design/hsl2rgb_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
package hsl2rgb_pkg;

    // Input word: one pixel in HSL, unsigned fixed point.
    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] lightness;
        logic [15:0] saturation;
    } t_hsl_word;

    // Output word: one pixel in 8-bit RGB.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_word;

    localparam int NUM_CH   = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Hue offset in thirds of a turn, plus one turn: red +1/3, green 0, blue -1/3.
    localparam logic [2:0] HUE_OFS [NUM_CH] = '{3'd4, 3'd3, 3'd2};

endpackage

// ----- design/hsl_to_rgb_converter_unit.sv -----
// HSL to 8-bit RGB pixel converter, five-stage pipeline.
//
//  channel | direction | handshake                      | word
//  --------+-----------+--------------------------------+---------------------------
//  hsl     | in        | i_hsl_valid / o_hsl_stall      | i_hsl (hue, lightness, sat)
//  rgb     | out       | o_rgb_valid / i_rgb_stall      | o_rgb (red, green, blue)
//
//  One word per cycle sustained while i_rgb_stall is low; an accepted word passes
//  five register stages (s1 to s4, then out) before it raises o_rgb_valid.
//  The critical path is one of the lane multipliers (FRAC_BITS+1 by FRAC_BITS+1).
//  Reset clears only the stage valid bits; data registers are left unreset.
//  Each stage moves when it is empty or the stage after it moves, so a stalled
//  output fills the bubbles ahead of it before the input stall is raised.
module hsl_to_rgb_converter_unit
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 15
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_hsl_valid,
    output logic      o_hsl_stall,
    input  t_hsl_word i_hsl,
    output logic      o_rgb_valid,
    input  logic      i_rgb_stall,
    output t_rgb_word o_rgb
);

    // Widths.
    //  VW: a fraction 0..ONE
    //  PW: a product held at scale ONE^2 (0..ONE^2)
    //  TW: hue position 3*(t+1) at scale ONE (0..7*ONE)
    localparam int F  = FRAC_BITS;
    localparam int VW = F + 1;
    localparam int PW = 2 * F + 1;
    localparam int TW = F + 3;
    localparam int XW = (VW > 16) ? VW : 16;

    localparam logic [XW-1:0] X_ONE   = XW'(1) << F;
    localparam logic [VW-1:0] V_ONE   = VW'(1) << F;
    localparam logic [TW-1:0] T_ONE   = TW'(1) << F;
    localparam logic [TW-1:0] T_THREE = TW'(3) << F;
    localparam logic [TW-1:0] T_FOUR  = TW'(4) << F;

    function automatic logic [VW-1:0] sat_in(input logic [15:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        return (vx > X_ONE) ? V_ONE : VW'(vx);
    endfunction

    // ---------------- handshake / stage enables ----------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_out_v || !i_rgb_stall;
    assign en4 = !r_s4_v  || en5;
    assign en3 = !r_s3_v  || en4;
    assign en2 = !r_s2_v  || en3;
    assign en1 = !r_s1_v  || en2;

    assign o_hsl_stall = !en1;
    assign o_rgb_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en1) r_s1_v  <= i_hsl_valid;
            if (en2) r_s2_v  <= r_s1_v;
            if (en3) r_s3_v  <= r_s2_v;
            if (en4) r_s4_v  <= r_s3_v;
            if (en5) r_out_v <= r_s4_v;
        end
    end

    // ---------------- stage 1: saturate, l*s, hue positions, grey level ----------------
    logic [VW-1:0]   n_h, n_s1_l, n_s1_s;
    logic [PW-1:0]   n_s1_ls;
    logic            n_s1_lo, n_s1_grey;
    logic [7:0]      n_s1_g;
    logic [F+1:0]    n_s1_t3 [NUM_CH];
    logic [2*VW-1:0] prod_ls;
    logic [VW+7:0]   l255;
    logic [TW-1:0]   u, t;

    logic [VW-1:0] r_s1_l, r_s1_s;
    logic [PW-1:0] r_s1_ls;
    logic          r_s1_lo, r_s1_grey;
    logic [7:0]    r_s1_g;
    logic [F+1:0]  r_s1_t3 [NUM_CH];

    always_comb begin
        n_h       = sat_in(i_hsl.hue);
        n_s1_l    = sat_in(i_hsl.lightness);
        n_s1_s    = sat_in(i_hsl.saturation);
        prod_ls   = n_s1_l * n_s1_s;
        n_s1_ls   = prod_ls[PW-1:0];
        n_s1_lo   = ({1'b0, n_s1_l} << 1) < (VW + 1)'(V_ONE);   // l < 1/2
        n_s1_grey = (n_s1_s == '0);
        l255      = ((VW + 8)'(n_s1_l) << 8) - (VW + 8)'(n_s1_l);
        n_s1_g    = l255[F+7:F];
        for (int c = 0; c < NUM_CH; c++) begin
            // 3*(t+1) = 3h + k, then wrap t into 0..1 (t = 1 kept)
            u = (TW'(n_h) << 1) + TW'(n_h) + (TW'(HUE_OFS[c]) << F);
            if (u < T_THREE) begin
                t = u;
            end else begin
                t = u - T_THREE;
                if (t > T_THREE) t = t - T_THREE;
            end
            n_s1_t3[c] = t[F+1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_l    <= n_s1_l;
            r_s1_s    <= n_s1_s;
            r_s1_ls   <= n_s1_ls;
            r_s1_lo   <= n_s1_lo;
            r_s1_grey <= n_s1_grey;
            r_s1_g    <= n_s1_g;
            for (int c = 0; c < NUM_CH; c++) r_s1_t3[c] <= n_s1_t3[c];
        end
    end

    // ---------------- stage 2: p and q-p at scale ONE^2, curve factors ----------------
    logic [PW-1:0] n_s2_p2, n_s2_d2;
    logic [VW-1:0] n_s2_f [NUM_CH];
    logic [PW-1:0] l_one, s_one;
    logic [PW:0]   p_hi;
    logic [TW-1:0] twice;

    logic [PW-1:0] r_s2_p2, r_s2_d2;
    logic [VW-1:0] r_s2_f [NUM_CH];
    logic          r_s2_grey;
    logic [7:0]    r_s2_g;

    always_comb begin
        l_one = PW'(r_s1_l) << F;
        s_one = PW'(r_s1_s) << F;
        p_hi  = (PW + 1)'(l_one) + (PW + 1)'(r_s1_ls) - (PW + 1)'(s_one);
        if (r_s1_lo) begin
            // q = l*ONE + l*s
            n_s2_p2 = l_one - r_s1_ls;
            n_s2_d2 = r_s1_ls << 1;
        end else begin
            // q = l*ONE + s*ONE - l*s
            n_s2_p2 = p_hi[PW-1:0];
            n_s2_d2 = (s_one - r_s1_ls) << 1;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            twice = TW'(r_s1_t3[c]) << 1;
            if (twice < T_ONE) begin
                n_s2_f[c] = VW'(twice);                // rising edge, 6t
            end else if (twice < T_THREE) begin
                n_s2_f[c] = V_ONE;                     // plateau at q
            end else if (TW'(r_s1_t3[c]) < (T_ONE << 1)) begin
                n_s2_f[c] = VW'(T_FOUR - twice);       // falling edge, 4-6t
            end else begin
                n_s2_f[c] = '0;                        // floor at p
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_p2   <= n_s2_p2;
            r_s2_d2   <= n_s2_d2;
            r_s2_grey <= r_s1_grey;
            r_s2_g    <= r_s1_g;
            for (int c = 0; c < NUM_CH; c++) r_s2_f[c] <= n_s2_f[c];
        end
    end

    // ---------------- stage 3: (q-p)*factor, split high and low halves ----------------
    logic [PW-1:0]   n_s3_mh [NUM_CH];
    logic [PW-1:0]   n_s3_ml [NUM_CH];
    logic [2*VW-1:0] prod_h;
    logic [PW-1:0]   prod_l;

    logic [PW-1:0] r_s3_p2;
    logic [PW-1:0] r_s3_mh [NUM_CH];
    logic [PW-1:0] r_s3_ml [NUM_CH];
    logic          r_s3_grey;
    logic [7:0]    r_s3_g;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod_h     = r_s2_d2[PW-1:F] * r_s2_f[c];
            prod_l     = PW'(r_s2_d2[F-1:0]) * PW'(r_s2_f[c]);
            n_s3_mh[c] = prod_h[PW-1:0];
            n_s3_ml[c] = prod_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_p2   <= r_s2_p2;
            r_s3_grey <= r_s2_grey;
            r_s3_g    <= r_s2_g;
            for (int c = 0; c < NUM_CH; c++) begin
                r_s3_mh[c] <= n_s3_mh[c];
                r_s3_ml[c] <= n_s3_ml[c];
            end
        end
    end

    // ---------------- stage 4: p + high part, scaled low part ----------------
    logic [PW:0]   n_s4_a [NUM_CH];
    logic [F+7:0]  n_s4_b [NUM_CH];
    logic [PW+7:0] ml255;

    logic [PW:0]  r_s4_a [NUM_CH];
    logic [F+7:0] r_s4_b [NUM_CH];
    logic         r_s4_grey;
    logic [7:0]   r_s4_g;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_s4_a[c] = (PW + 1)'(r_s3_p2) + (PW + 1)'(r_s3_mh[c]);
            ml255     = ((PW + 8)'(r_s3_ml[c]) << 8) - (PW + 8)'(r_s3_ml[c]);
            n_s4_b[c] = ml255[2*F+7:F];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_grey <= r_s3_grey;
            r_s4_g    <= r_s3_g;
            for (int c = 0; c < NUM_CH; c++) begin
                r_s4_a[c] <= n_s4_a[c];
                r_s4_b[c] <= n_s4_b[c];
            end
        end
    end

    // ---------------- stage 5: 255*value at scale ONE^2, take the byte ----------------
    logic [7:0]    n_ch [NUM_CH];
    logic [PW+9:0] x;
    t_rgb_word     n_out, r_out;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            x = ((PW + 10)'(r_s4_a[c]) << 8) - (PW + 10)'(r_s4_a[c])
              + (PW + 10)'(r_s4_b[c]);
            n_ch[c] = r_s4_grey ? r_s4_g : x[2*F+7:2*F];
        end
        n_out.red   = n_ch[CH_RED];
        n_out.green = n_ch[CH_GREEN];
        n_out.blue  = n_ch[CH_BLUE];
    end

    always_ff @(posedge i_clk) begin
        if (en5) r_out <= n_out;
    end

    assign o_rgb = r_out;

endmodule
